[rtl/pcf_pkg.sv]
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and byte codes for the printer controller filter.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int HOLD_DEPTH  = 3;
    localparam int HCW         = $clog2(HOLD_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] C_NUL  = 8'h00;
    localparam logic [7:0] C_XON  = 8'h11;
    localparam logic [7:0] C_XOFF = 8'h13;
    localparam logic [7:0] C_ESC  = 8'h1B;
    localparam logic [7:0] C_CSI  = 8'h9B;
    localparam logic [7:0] C_LBR  = 8'h5B;
    localparam logic [7:0] C_FOUR = 8'h34;
    localparam logic [7:0] C_FIVE = 8'h35;
    localparam logic [7:0] C_I    = 8'h69;

    // one classified word: held bytes to flush, then an optional tail byte
    typedef struct packed {
        logic [HOLD_DEPTH-1:0][7:0] held;
        logic [HCW-1:0]             cnt;
        logic                       tail_en;
        logic [7:0]                 tail;
        logic                       to_printer;
        logic                       mode_on;
    } t_bundle;

endpackage

[rtl/pcf_front.sv]
// ----------------------------------------------------------------------------
// pcf_front
// Sequence parser: accepts words, tracks controller mode and held bytes,
// and emits one bundle per word that produces output.
// ----------------------------------------------------------------------------
module pcf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_func,
    input  logic [7:0]       i_byte,
    output logic             o_push,
    output pcf_pkg::t_bundle o_bundle
);
    import pcf_pkg::*;

    localparam logic [2:0] ST_GROUND  = 3'd0;
    localparam logic [2:0] ST_ESC     = 3'd1;
    localparam logic [2:0] ST_CSI     = 3'd2;
    localparam logic [2:0] ST_BRACKET = 3'd3;
    localparam logic [2:0] ST_FOUR    = 3'd4;
    localparam logic [2:0] ST_FIVE    = 3'd5;

    logic [2:0]                 r_st, n_st, st_in;
    logic [HCW-1:0]             r_cnt, n_cnt, base_cnt;
    logic                       r_mode, n_mode;
    logic [HOLD_DEPTH-1:0][7:0] r_held;
    logic                       flush, clr, hold_en, tail_en, to_pr, wr_en;

    always_comb begin
        st_in    = (r_st > ST_FIVE) ? ST_GROUND : r_st;
        n_st     = st_in;
        n_mode   = r_mode;
        flush    = 1'b0;
        clr      = 1'b0;
        hold_en  = 1'b0;
        tail_en  = 1'b0;
        to_pr    = 1'b1;
        if (i_func) begin
            n_mode = 1'b1;
            n_st   = r_st;
        end else if (!r_mode) begin
            tail_en = 1'b1;
            to_pr   = 1'b0;
            n_st    = r_st;
        end else begin
            unique case (i_byte)
                C_NUL, C_XON, C_XOFF: begin
                    flush = 1'b1;
                end
                C_ESC, C_CSI: begin
                    flush   = 1'b1;
                    hold_en = 1'b1;
                    n_st    = (i_byte == C_ESC) ? ST_ESC : ST_CSI;
                end
                C_LBR: begin
                    if (st_in == ST_ESC) begin
                        hold_en = 1'b1;
                        n_st    = ST_BRACKET;
                    end else begin
                        flush   = 1'b1;
                        tail_en = 1'b1;
                        n_st    = ST_GROUND;
                    end
                end
                C_FOUR, C_FIVE: begin
                    if (st_in == ST_BRACKET || st_in == ST_CSI) begin
                        hold_en = 1'b1;
                        n_st    = (i_byte == C_FOUR) ? ST_FOUR : ST_FIVE;
                    end else begin
                        flush   = 1'b1;
                        tail_en = 1'b1;
                        n_st    = ST_GROUND;
                    end
                end
                C_I: begin
                    n_st = ST_GROUND;
                    if (st_in == ST_FOUR) begin
                        clr    = 1'b1;
                        n_mode = 1'b0;
                    end else if (st_in == ST_FIVE) begin
                        clr = 1'b1;
                    end else begin
                        flush   = 1'b1;
                        tail_en = 1'b1;
                    end
                end
                default: begin
                    flush   = 1'b1;
                    tail_en = 1'b1;
                    n_st    = ST_GROUND;
                end
            endcase
        end
        base_cnt = (flush || clr) ? '0 : r_cnt;
        wr_en    = hold_en && (base_cnt < HCW'(HOLD_DEPTH));
        n_cnt    = wr_en ? base_cnt + HCW'(1) : base_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_GROUND;
            r_cnt  <= '0;
            r_mode <= 1'b0;
        end else if (i_accept) begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            r_held[base_cnt] <= i_byte;
        end
    end

    always_comb begin
        o_bundle.held       = r_held;
        o_bundle.cnt        = flush ? r_cnt : '0;
        o_bundle.tail_en    = tail_en;
        o_bundle.tail       = i_byte;
        o_bundle.to_printer = to_pr;
        o_bundle.mode_on    = n_mode;
        o_push = i_accept && (tail_en || (flush && (r_cnt != '0)));
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= HCW'(HOLD_DEPTH))
        else $error("hold count out of range");
    a_off_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_func && r_mode && !n_mode) |=> (r_cnt == '0 && r_st == ST_GROUND))
        else $error("mode off left held state");
    a_push_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_bundle.to_printer == r_mode))
        else $error("destination does not follow mode");

endmodule

[rtl/pcf_queue.sv]
// ----------------------------------------------------------------------------
// pcf_queue
// Small register FIFO of bundles between the parser and the emitter.
// ----------------------------------------------------------------------------
module pcf_queue #(
    parameter int DEPTH = pcf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcf_pkg::t_bundle i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output pcf_pkg::t_bundle o_data
);
    import pcf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_count;
    logic            push_ok, pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_count <= r_count + CW'(push_ok) - CW'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !pop_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count lost a push");

endmodule

[rtl/pcf_back.sv]
// ----------------------------------------------------------------------------
// pcf_back
// Emitter: walks a bundle, held bytes then tail, a word per cycle while ready.
// ----------------------------------------------------------------------------
module pcf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  pcf_pkg::t_bundle i_q_data,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_to_printer,
    output logic             o_last,
    output logic             o_mode_on
);
    import pcf_pkg::*;

    t_bundle          r_bun;
    logic             r_busy;
    logic [HCW-1:0]   r_idx;
    logic [HCW:0]     total;
    logic             last, load;

    assign total = {1'b0, r_bun.cnt} + (HCW+1)'(r_bun.tail_en);
    assign last  = ({1'b0, r_idx} + (HCW+1)'(1)) == total;
    assign load  = !r_busy || (i_ready && last);
    assign o_q_pop = load && !i_q_empty;

    always_comb begin
        o_byte = r_bun.tail;
        for (int k = 0; k < HOLD_DEPTH; k++) begin
            if (r_idx == HCW'(k) && r_idx < r_bun.cnt) begin
                o_byte = r_bun.held[k];
            end
        end
    end

    assign o_valid      = r_busy;
    assign o_to_printer = r_bun.to_printer;
    assign o_mode_on    = r_bun.mode_on;
    assign o_last       = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= !i_q_empty;
            r_idx  <= '0;
        end else if (i_ready) begin
            r_idx <= r_idx + HCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_q_empty) begin
            r_bun <= i_q_data;
        end
    end

    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (total != '0))
        else $error("empty bundle in emitter");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_idx} < total))
        else $error("emitter index past bundle");
    a_idle_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_ready && last && i_q_empty) |=> !r_busy)
        else $error("emitter stayed busy after drain");

endmodule

[rtl/printer_controller_filter.sv]
// ----------------------------------------------------------------------------
// printer_controller_filter
// Printer controller mode filter: parser front, bundle queue, byte emitter.
// ----------------------------------------------------------------------------
//  channel  dir  tdata        tuser                      tlast
//  s        in   in_byte[7:0] func                       -
//  m        out  out_byte     [0] to_printer [1] mode_on last_of_run
//
//  Input words are taken one per cycle while the queue has room.
//  A word yields 0 to 4 output words; the emitter sends one per cycle while
//  m_tready is high, and holds a word's results until all are sent.
//  Output words pass through the queue and the emitter's bundle register.
//  Reset is synchronous, active low; no clearing pass after reset.
// ----------------------------------------------------------------------------
module printer_controller_filter #(
    parameter int QUEUE_DEPTH = pcf_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tuser,   // [0] func
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_tuser,   // [0] to_printer, [1] mode_on
    output logic       o_m_tlast
);
    import pcf_pkg::*;

    t_bundle push_data, head;
    logic    accept, push, full, empty, pop;
    logic    to_pr, mode_on;

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && !full;

    pcf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_func   (i_s_tuser),
        .i_byte   (i_s_tdata),
        .o_push   (push),
        .o_bundle (push_data)
    );

    pcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (head)
    );

    pcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (empty),
        .i_q_data     (head),
        .o_q_pop      (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (o_m_tdata),
        .o_to_printer (to_pr),
        .o_last       (o_m_tlast),
        .o_mode_on    (mode_on)
    );

    assign o_m_tuser = {mode_on, to_pr};

endmodule
